### sv/smwi_pkg.sv
// ----------------------------------------------------------------------------
// smwi_pkg
// shared types and constants for the sign-magnitude wide integer unit
// ----------------------------------------------------------------------------
package smwi_pkg;

    localparam int LIMBS      = 4;
    localparam int LIMB_BITS  = 32;
    localparam int LIDX_W     = (LIMBS > 1) ? $clog2(LIMBS) : 1;
    localparam int CNT_W      = 7;
    localparam int TOTAL_BITS = LIMBS * LIMB_BITS;
    localparam int BIT_W      = $clog2(TOTAL_BITS + 1);

    typedef logic [LIMB_BITS-1:0] limb_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_SHL = 3'd3,
        OP_NEG = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CMP,
        ST_ADDSUB,
        ST_MUL,
        ST_MULADD,
        ST_SHL,
        ST_OUT
    } state_t;

endpackage

### sv/sign_magnitude_wide_integer_alu_top.sv
// ----------------------------------------------------------------------------
// sign_magnitude_wide_integer_alu_top
// bit-serial sign-magnitude wide integer unit: add, subtract, multiply,
// left shift and negate over LIMBS 32-bit limbs
// ----------------------------------------------------------------------------
// latency from the last input word to the first result word follows the path: negate,
// unused codes and shifts by 0 or LIMBS*32 or more go straight to output, a shift by n
// shifts the stored value left one bit per step, add/subtract run a compare pass then
// a serial add pass, multiply scans B and runs a serial add pass per set bit of B
// throughput: input words one per cycle, then input stalls until the LIMBS result words
// have left, one per cycle with m_ready high; reset clears control state only, stores undefined
module sign_magnitude_wide_integer_alu_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [31:0] s_a_limb,
    input  logic [31:0] s_b_limb,
    input  logic        s_a_negative,
    input  logic        s_b_negative,
    input  logic [11:0] s_shift_amount,
    input  logic        s_last_limb,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_limb,
    output logic        m_result_negative,
    output logic        m_result_zero,
    output logic        m_result_last
);

    localparam int TB = smwi_pkg::TOTAL_BITS;
    localparam int BW = smwi_pkg::BIT_W;
    localparam int LB = smwi_pkg::LIMB_BITS;

    smwi_pkg::state_t state_reg, state_next;

    logic [TB-1:0]                a_reg, a_next;
    logic [TB-1:0]                b_reg, b_next;
    logic [TB-1:0]                r_reg, r_next;
    logic [TB-1:0]                m_reg, m_next;
    logic [smwi_pkg::CNT_W-1:0]   load_reg, load_next;
    logic [BW-1:0]                cnt_reg, cnt_next;
    logic [BW-1:0]                bidx_reg, bidx_next;
    logic [11:0]                  sh_reg, sh_next;
    logic                         carry_reg, carry_next;
    logic                         swap_reg, swap_next;
    logic                         sub_reg, sub_next;
    logic                         neg_reg, neg_next;
    logic                         pz_reg, pz_next;
    logic                         an_reg, an_next;
    logic                         bn_reg, bn_next;
    logic [smwi_pkg::LIDX_W-1:0]  oidx_reg, oidx_next;

    logic                         acc_in;
    logic                         eff_bn;
    logic                         ge;
    logic                         sx, sy, bs, bo;
    logic                         r_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smwi_pkg::ST_LOAD;
            load_reg  <= '0;
        end else begin
            state_reg <= state_next;
            load_reg  <= load_next;
        end
        a_reg     <= a_next;
        b_reg     <= b_next;
        r_reg     <= r_next;
        m_reg     <= m_next;
        cnt_reg   <= cnt_next;
        bidx_reg  <= bidx_next;
        sh_reg    <= sh_next;
        carry_reg <= carry_next;
        swap_reg  <= swap_next;
        sub_reg   <= sub_next;
        neg_reg   <= neg_next;
        pz_reg    <= pz_next;
        an_reg    <= an_next;
        bn_reg    <= bn_next;
        oidx_reg  <= oidx_next;
    end

    assign acc_in = s_valid && s_ready;
    assign eff_bn = (s_operation == smwi_pkg::OP_SUB) ? !s_b_negative : s_b_negative;
    assign r_zero = (r_reg == '0);

    // a - b borrow chain, carry out set means a >= b
    assign ge = (a_reg[0] & ~b_reg[0]) | (a_reg[0] & carry_reg) | (~b_reg[0] & carry_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smwi_pkg::ST_LOAD: begin
                if (acc_in && s_last_limb) begin
                    case (s_operation)
                        smwi_pkg::OP_ADD, smwi_pkg::OP_SUB: state_next = smwi_pkg::ST_CMP;
                        smwi_pkg::OP_MUL: state_next = smwi_pkg::ST_MUL;
                        smwi_pkg::OP_SHL: begin
                            if (s_shift_amount == '0 || s_shift_amount >= 12'(TB)) begin
                                state_next = smwi_pkg::ST_OUT;
                            end else begin
                                state_next = smwi_pkg::ST_SHL;
                            end
                        end
                        default: state_next = smwi_pkg::ST_OUT;
                    endcase
                end
            end
            smwi_pkg::ST_CMP: begin
                if (cnt_reg == BW'(TB - 1)) begin
                    state_next = smwi_pkg::ST_ADDSUB;
                end
            end
            smwi_pkg::ST_ADDSUB: begin
                if (cnt_reg == BW'(TB - 1)) begin
                    state_next = smwi_pkg::ST_OUT;
                end
            end
            smwi_pkg::ST_MUL: begin
                if (b_reg[0]) begin
                    state_next = smwi_pkg::ST_MULADD;
                end else if (bidx_reg == BW'(TB - 1)) begin
                    state_next = smwi_pkg::ST_OUT;
                end
            end
            smwi_pkg::ST_MULADD: begin
                if (cnt_reg == BW'(TB - 1)) begin
                    if (bidx_reg == BW'(TB - 1)) begin
                        state_next = smwi_pkg::ST_OUT;
                    end else begin
                        state_next = smwi_pkg::ST_MUL;
                    end
                end
            end
            smwi_pkg::ST_SHL: begin
                if (sh_reg == 12'd1) begin
                    state_next = smwi_pkg::ST_OUT;
                end
            end
            smwi_pkg::ST_OUT: begin
                if (m_ready && oidx_reg == smwi_pkg::LIDX_W'(smwi_pkg::LIMBS - 1)) begin
                    state_next = smwi_pkg::ST_LOAD;
                end
            end
            default: state_next = smwi_pkg::ST_LOAD;
        endcase
    end

    // serial full adder: accumulate for multiply, operand pair otherwise
    always_comb begin
        if (state_reg == smwi_pkg::ST_MULADD) begin
            sx = r_reg[0];
            sy = m_reg[0];
        end else begin
            sx = swap_reg ? b_reg[0] : a_reg[0];
            sy = (swap_reg ? a_reg[0] : b_reg[0]) ^ sub_reg;
        end
        bs = sx ^ sy ^ carry_reg;
        bo = (sx & sy) | (sx & carry_reg) | (sy & carry_reg);
    end

    always_comb begin
        a_next     = a_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        m_next     = m_reg;
        load_next  = load_reg;
        cnt_next   = cnt_reg;
        bidx_next  = bidx_reg;
        sh_next    = sh_reg;
        carry_next = carry_reg;
        swap_next  = swap_reg;
        sub_next   = sub_reg;
        neg_next   = neg_reg;
        pz_next    = pz_reg;
        an_next    = an_reg;
        bn_next    = bn_reg;
        oidx_next  = oidx_reg;
        case (state_reg)
            smwi_pkg::ST_LOAD: begin
                if (acc_in) begin
                    if (load_reg < smwi_pkg::CNT_W'(smwi_pkg::LIMBS)) begin
                        a_next[load_reg[smwi_pkg::LIDX_W-1:0]*LB +: LB] = s_a_limb;
                        b_next[load_reg[smwi_pkg::LIDX_W-1:0]*LB +: LB] = s_b_limb;
                        load_next = load_reg + 1'b1;
                    end
                    if (s_last_limb) begin
                        load_next  = '0;
                        cnt_next   = '0;
                        bidx_next  = '0;
                        oidx_next  = '0;
                        swap_next  = 1'b0;
                        carry_next = 1'b1;
                        an_next    = s_a_negative;
                        bn_next    = eff_bn;
                        sub_next   = s_a_negative != eff_bn;
                        sh_next    = s_shift_amount;
                        m_next     = a_next;
                        r_next     = '0;
                        neg_next   = 1'b0;
                        pz_next    = 1'b1;
                        case (s_operation)
                            smwi_pkg::OP_MUL: begin
                                neg_next = s_a_negative ^ s_b_negative;
                            end
                            smwi_pkg::OP_SHL: begin
                                pz_next  = 1'b0;
                                neg_next = s_a_negative;
                                if (s_shift_amount < 12'(TB)) begin
                                    r_next = a_next;
                                end
                            end
                            smwi_pkg::OP_NEG: begin
                                pz_next  = 1'b0;
                                r_next   = a_next;
                                neg_next = (a_next == '0) ? s_a_negative : !s_a_negative;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            smwi_pkg::ST_CMP: begin
                a_next     = {a_reg[0], a_reg[TB-1:1]};
                b_next     = {b_reg[0], b_reg[TB-1:1]};
                carry_next = ge;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == BW'(TB - 1)) begin
                    cnt_next   = '0;
                    swap_next  = sub_reg && !ge;
                    carry_next = sub_reg;
                    neg_next   = (sub_reg && !ge) ? bn_reg : an_reg;
                end
            end
            smwi_pkg::ST_ADDSUB: begin
                a_next     = {a_reg[0], a_reg[TB-1:1]};
                b_next     = {b_reg[0], b_reg[TB-1:1]};
                r_next     = {bs, r_reg[TB-1:1]};
                carry_next = bo;
                cnt_next   = cnt_reg + 1'b1;
            end
            smwi_pkg::ST_MUL: begin
                if (b_reg[0]) begin
                    cnt_next   = '0;
                    carry_next = 1'b0;
                end else begin
                    m_next    = m_reg << 1;
                    b_next    = {b_reg[0], b_reg[TB-1:1]};
                    bidx_next = bidx_reg + 1'b1;
                end
            end
            smwi_pkg::ST_MULADD: begin
                r_next     = {bs, r_reg[TB-1:1]};
                m_next     = {m_reg[0], m_reg[TB-1:1]};
                carry_next = bo;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == BW'(TB - 1)) begin
                    // rotated back into place and moved up one bit
                    m_next    = {m_reg[TB-1:1], 1'b0};
                    b_next    = {b_reg[0], b_reg[TB-1:1]};
                    bidx_next = bidx_reg + 1'b1;
                end
            end
            smwi_pkg::ST_SHL: begin
                r_next  = r_reg << 1;
                sh_next = sh_reg - 1'b1;
            end
            smwi_pkg::ST_OUT: begin
                if (m_ready) begin
                    r_next    = {r_reg[LB-1:0], r_reg[TB-1:LB]};
                    oidx_next = oidx_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        s_ready           = (state_reg == smwi_pkg::ST_LOAD);
        m_valid           = (state_reg == smwi_pkg::ST_OUT);
        m_result_limb     = r_reg[LB-1:0];
        m_result_negative = neg_reg && !(pz_reg && r_zero);
        m_result_zero     = r_zero;
        m_result_last     = (oidx_reg == smwi_pkg::LIDX_W'(smwi_pkg::LIMBS - 1));
    end

`ifndef SYNTH
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while emitting");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_result_last) |=> s_ready)
        else $error("no return to load after last word");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_limb)))
        else $error("result word changed while waiting");
`endif

endmodule
